// ----- rtl/ps2kc_pkg.sv -----
// shared constants and types for the keyboard controller port block
`default_nettype none

package ps2kc_pkg;

    localparam int RAM_WORDS = 64;
    localparam int RAM_AW    = $clog2(RAM_WORDS);

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_KEY_ENQ = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    localparam logic [15:0] PORT_DATA   = 16'h0060;
    localparam logic [15:0] PORT_SYSCTL = 16'h0061;
    localparam logic [15:0] PORT_STATUS = 16'h0064;

    localparam logic [7:0] OP_SET_LEDS = 8'hED;
    localparam logic [7:0] OP_KBD_OFF  = 8'hAD;
    localparam logic [7:0] OP_KBD_ON   = 8'hAE;
    localparam logic [7:0] OP_OUT_PORT = 8'hD1;
    localparam logic [7:0] ACK_BYTE    = 8'hFA;

    localparam logic [7:0] RAM_RD_MAX     = 8'h3F;
    localparam logic [7:0] RAM_WR_MIN     = 8'h60;
    localparam logic [7:0] RAM_WR_MAX     = 8'h7F;
    localparam logic [7:0] CMD_BYTE_RESET = 8'h15;
    localparam logic [7:0] SYSCTL_TOGGLE  = 8'h10;
    localparam logic [7:0] A20_MASK       = 8'h02;

endpackage

`default_nettype wire

// ----- rtl/ps2kc_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none

module ps2kc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/ps2_keyboard_controller_ports_core.sv -----
// top level of the keyboard controller port block
// Takes one port access or key-enqueue notice per cycle and returns one result item for each,
// in the cycle after acceptance, from an output register; the input side stays ready while that
// register is empty or being taken. Each item is decoded combinationally. The 64-byte
// controller ram is a memory whose read port is always addressed by the pending command, so
// the byte for a ram-read command is already registered when the data port is read. Per-entry
// valid bits make unwritten bytes read as zero (byte 0 as 0x15); the command byte is also kept
// in flip-flops for status and interrupt decode. No clearing pass is needed after reset.
`default_nettype none

module ps2_keyboard_controller_ports_core
    import ps2kc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [15:0] s_port_addr,
    input  wire logic [7:0]  s_write_data,
    input  wire logic [7:0]  s_key_byte,
    input  wire logic        s_key_available,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data,
    output logic             m_key_popped,
    output logic             m_irq_raise,
    output logic [7:0]       m_led_state,
    output logic             m_led_changed,
    output logic             m_gate_a20_strobe,
    output logic             m_gate_a20_value
);

    // controller state
    logic [7:0]           pending_reg, pending_next;
    logic                 cmd_pend_reg, cmd_pend_next;
    logic                 last_wr_cmd_reg, last_wr_cmd_next;
    logic                 kbd_en_reg, kbd_en_next;
    logic [7:0]           led_reg, led_next;
    logic [7:0]           sysctl_reg, sysctl_next;
    logic [7:0]           cmd_byte_reg, cmd_byte_next;
    logic [RAM_WORDS-1:0] ram_valid_reg, ram_valid_next;

    // result register
    logic                 m_valid_reg;
    logic [7:0]           rd_data_reg, rd_data_next;
    logic                 popped_reg, popped_next;
    logic                 irq_reg, irq_next;
    logic                 ledch_reg, ledch_next;
    logic                 strobe_reg, strobe_next;
    logic                 a20_reg, a20_next;

    logic                 accept;
    logic                 ram_we;
    logic [RAM_AW-1:0]    ram_waddr;
    logic [RAM_AW-1:0]    pend_idx;
    logic [7:0]           ram_rdata;
    logic [7:0]           ram_byte;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign pend_idx  = pending_reg[RAM_AW-1:0];
    assign ram_waddr = pend_idx;

    // unwritten entries read as their reset value
    always_comb begin
        if (ram_valid_reg[pend_idx]) begin
            ram_byte = ram_rdata;
        end else if (pend_idx == '0) begin
            ram_byte = CMD_BYTE_RESET;
        end else begin
            ram_byte = '0;
        end
    end

    ps2kc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_WORDS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_write_data),
        .rd_addr (pending_next[RAM_AW-1:0]),
        .rd_data (ram_rdata)
    );

    always_comb begin
        pending_next     = pending_reg;
        cmd_pend_next    = cmd_pend_reg;
        last_wr_cmd_next = last_wr_cmd_reg;
        kbd_en_next      = kbd_en_reg;
        led_next         = led_reg;
        sysctl_next      = sysctl_reg;
        cmd_byte_next    = cmd_byte_reg;
        ram_valid_next   = ram_valid_reg;
        ram_we           = 1'b0;
        rd_data_next     = '0;
        popped_next      = 1'b0;
        irq_next         = 1'b0;
        ledch_next       = 1'b0;
        strobe_next      = 1'b0;
        a20_next         = 1'b0;

        if (accept) begin
            unique case (cmd_t'(s_cmd))
                CMD_READ: begin
                    if (s_port_addr == PORT_DATA) begin
                        priority if (cmd_pend_reg && pending_reg <= RAM_RD_MAX) begin
                            cmd_pend_next = 1'b0;
                            rd_data_next  = ram_byte;
                        end else if (last_wr_cmd_reg && pending_reg == OP_SET_LEDS) begin
                            rd_data_next = ACK_BYTE;
                        end else if (s_key_available) begin
                            rd_data_next = s_key_byte;
                            popped_next  = 1'b1;
                        end else begin
                            rd_data_next = '0;
                        end
                    end else if (s_port_addr == PORT_STATUS) begin
                        rd_data_next = {3'b000, kbd_en_reg, last_wr_cmd_reg,
                                        cmd_byte_reg[2], 1'b0, s_key_available};
                    end else if (s_port_addr == PORT_SYSCTL) begin
                        sysctl_next  = sysctl_reg ^ SYSCTL_TOGGLE;
                        rd_data_next = sysctl_reg ^ SYSCTL_TOGGLE;
                    end
                end
                CMD_WRITE: begin
                    if (s_port_addr == PORT_SYSCTL) begin
                        sysctl_next = s_write_data;
                    end else if (s_port_addr == PORT_STATUS) begin
                        priority if (s_write_data == OP_KBD_ON) begin
                            kbd_en_next = 1'b1;
                        end else if (s_write_data == OP_KBD_OFF) begin
                            kbd_en_next = 1'b0;
                        end else begin
                            pending_next     = s_write_data;
                            cmd_pend_next    = 1'b1;
                            last_wr_cmd_next = 1'b1;
                        end
                    end else if (s_port_addr == PORT_DATA) begin
                        last_wr_cmd_next = 1'b0;
                        if (!cmd_pend_reg) begin
                            if (s_write_data == OP_SET_LEDS) begin
                                pending_next     = s_write_data;
                                cmd_pend_next    = 1'b1;
                                last_wr_cmd_next = 1'b1;
                            end
                        end else begin
                            cmd_pend_next = 1'b0;
                            priority if (pending_reg == OP_SET_LEDS) begin
                                if (led_reg != s_write_data) begin
                                    led_next   = s_write_data;
                                    ledch_next = 1'b1;
                                end
                            end else if (pending_reg == OP_OUT_PORT) begin
                                strobe_next = 1'b1;
                                a20_next    = |(s_write_data & A20_MASK);
                            end else if (pending_reg >= RAM_WR_MIN
                                         && pending_reg <= RAM_WR_MAX) begin
                                ram_we                   = 1'b1;
                                ram_valid_next[pend_idx] = 1'b1;
                                if (pend_idx == '0) begin
                                    cmd_byte_next = s_write_data;
                                end
                            end else begin
                                // unknown command: byte dropped
                                cmd_pend_next = 1'b0;
                            end
                        end
                    end
                end
                CMD_KEY_ENQ: begin
                    irq_next = cmd_byte_reg[0];
                end
                CMD_NOP: begin
                    irq_next = 1'b0;
                end
                default: begin
                    irq_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg     <= '0;
            cmd_pend_reg    <= 1'b0;
            last_wr_cmd_reg <= 1'b0;
            kbd_en_reg      <= 1'b1;
            led_reg         <= '0;
            sysctl_reg      <= '0;
            cmd_byte_reg    <= CMD_BYTE_RESET;
            ram_valid_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            pending_reg     <= pending_next;
            cmd_pend_reg    <= cmd_pend_next;
            last_wr_cmd_reg <= last_wr_cmd_next;
            kbd_en_reg      <= kbd_en_next;
            led_reg         <= led_next;
            sysctl_reg      <= sysctl_next;
            cmd_byte_reg    <= cmd_byte_next;
            ram_valid_reg   <= ram_valid_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= rd_data_next;
            popped_reg  <= popped_next;
            irq_reg     <= irq_next;
            ledch_reg   <= ledch_next;
            strobe_reg  <= strobe_next;
            a20_reg     <= a20_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_read_data       = rd_data_reg;
    assign m_key_popped      = popped_reg;
    assign m_irq_raise       = irq_reg;
    assign m_led_state       = led_reg;
    assign m_led_changed     = ledch_reg;
    assign m_gate_a20_strobe = strobe_reg;
    assign m_gate_a20_value  = a20_reg;

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted item produced no result");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    a_a20_value_only_with_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_gate_a20_strobe) |-> !m_gate_a20_value)
        else $error("a20 value without strobe");

    a_single_effect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_key_popped, m_irq_raise, m_led_changed,
                                m_gate_a20_strobe}) <= 1)
        else $error("one item raised more than one effect");

    a_led_change_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ledch_next) |=> (m_led_state != $past(led_reg)))
        else $error("led change flagged but led byte unchanged");

endmodule

`default_nettype wire
